>>> src/bitmap_block_allocator_assert.svh
// Assertion macros for the bitmap block allocator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every clock edge out of reset
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap block allocator assertion failed");
// Next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap block allocator assertion failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> src/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// No dependencies; imported by the interfaces, the divider and the top level.
package bba_pkg;

    // Sizing defaults and fixed field widths
    localparam int MAX_BUCKETS_DEF = 8;
    localparam int MAX_BLOCKS_DEF  = 256;
    localparam int WORD_BITS       = 32;
    localparam int WORD_LOG        = 5;
    localparam int OFFSET_W        = 24;
    localparam int BSIZE_W         = 17;
    localparam int BUCKET_W        = 3;
    localparam int INDEX_W         = 8;
    localparam int STATUS_W        = 3;
    localparam int NBLK_CFG_W      = 9;
    localparam int NBKT_CFG_W      = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 17;
    localparam int DIV_CNT_W       = 5;

    localparam logic [BSIZE_W-1:0]    MAX_BLOCK_BYTES  = 17'd65536;
    localparam logic [BSIZE_W-1:0]    RST_BLOCK_BYTES  = 17'd64;
    localparam logic [NBLK_CFG_W-1:0] RST_BLOCKS       = 9'd256;
    localparam logic [NBKT_CFG_W-1:0] RST_BUCKETS      = 4'd8;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_ALLOCATED  = 3'd0,
        STS_FULL       = 3'd1,
        STS_BAD_BUCKET = 3'd2,
        STS_FREED      = 3'd3,
        STS_BAD_OFFSET = 3'd4,
        STS_NOT_USED   = 3'd5
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_BYTES    = 2'd0,
        CFG_BLOCKS_IN_USE  = 2'd1,
        CFG_BUCKETS_IN_USE = 2'd2
    } t_cfg_idx;

    // Divider result toward the sequencer
    typedef struct packed {
        logic                done;
        logic                exact;
        logic [OFFSET_W-1:0] quot;
    } t_div_res;

endpackage

>>> src/bba_intf.sv
// Channel interfaces of the bitmap block allocator: request, response, config.
// Depends on bba_pkg for field widths.
interface bba_req_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [BUCKET_W-1:0] bucket_sel;
    logic [OFFSET_W-1:0] free_offset;

    modport source (output valid, opcode, bucket_sel, free_offset, input ready);
    modport sink   (input valid, opcode, bucket_sel, free_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] block_offset;

    modport source (output valid, status, block_index, block_offset, input ready);
    modport sink   (input valid, status, block_index, block_offset, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/bba_div.sv
// Restoring divider, one quotient bit per cycle, for free-offset decoding.
// Depends on bba_pkg for widths and the result struct.
module bba_div import bba_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [OFFSET_W-1:0] i_dividend,
    input  logic [BSIZE_W-1:0]  i_divisor,
    output t_div_res            o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [OFFSET_W-1:0]  r_q;
    logic [BSIZE_W-1:0]   r_rem;
    logic [BSIZE_W-1:0]   r_dvs;

    logic [BSIZE_W:0]     w_sh;
    logic [BSIZE_W:0]     w_diff;
    logic                 w_ge;

    // Shift in the next dividend bit and try the subtraction
    assign w_sh   = {r_rem, r_q[OFFSET_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(OFFSET_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as the quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[OFFSET_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[BSIZE_W-1:0] : w_sh[BSIZE_W-1:0];
        end
    end

    assign o_res.done  = r_done;
    assign o_res.exact = (r_rem == '0);
    assign o_res.quot  = r_q;

endmodule

>>> src/bitmap_block_allocator.sv
// Bitmap block allocator: occupancy bitmap memory, request sequencer, outputs.
// Depends on bba_pkg, bba_intf.sv, bba_div and bitmap_block_allocator_assert.svh.
//
// Usage:
//   i_req carries one request per beat: opcode (allocate or free), bucket_sel
//   and free_offset. o_rsp returns exactly one beat per request with status,
//   block_index and block_offset. i_cfg writes block_bytes (index 0),
//   blocks_in_use (1) and buckets_in_use (2); it is always ready and must
//   only be written while no request is outstanding.
// Sequencing:
//   One request is worked at a time; i_req.ready is low while it runs.
//   Bad bucket, or allocate with zero blocks: ST_IDLE goes straight to ST_RESP.
//   Allocate: each bitmap word scanned passes ST_READ (memory read) and
//   ST_EVAL (lowest-free-bit search); a found block then passes ST_MUL and
//   ST_RESP, while a full bucket, which scans every word in use, goes to ST_RESP.
//   Free: the bit-serial offset divider (ST_DIV), then one read-modify-write
//   of the bitmap word (ST_READ, ST_EVAL); a bad offset skips to ST_RESP.
// Reset:
//   Configuration returns to 64-byte blocks, 256 blocks, 8 buckets. A clearing
//   pass then zeroes the bitmap memory, one word per cycle, all MAX_BUCKETS *
//   ceil(MAX_BLOCKS / 32) words (64 at the defaults), before i_req goes ready.
// Stalls:
//   A finished response waits in the output register while o_rsp.ready is low;
//   a new request is still accepted, and its response waits for the register.
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator import bba_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp,
    bba_cfg_if.sink   i_cfg
);

    localparam int WPB   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL = MAX_BUCKETS * WPB;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int WI_W  = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int BLK_W = $clog2(MAX_BLOCKS);
    localparam int NB_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PRD_W = BLK_W + BSIZE_W;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_EVAL  = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_RESP  = 7'b1000000
    } t_state;

    // Configuration registers
    logic [BSIZE_W-1:0]    r_cfg_bsz;
    logic [NBLK_CFG_W-1:0] r_cfg_nblk;
    logic [NBKT_CFG_W-1:0] r_cfg_nbkt;

    // Sequencer and working registers
    t_state               r_state;
    logic [AW-1:0]        r_clr;
    logic                 r_op;
    logic [BUCKET_W-1:0]  r_bucket;
    logic [WI_W-1:0]      r_word;
    logic [WORD_LOG-1:0]  r_bitpos;
    logic [BLK_W-1:0]     r_blk;
    logic [OFFSET_W-1:0]  r_off;
    t_status              r_st;

    // Bitmap memory
    logic [WORD_BITS-1:0] r_mem [TOTAL];
    logic [WORD_BITS-1:0] r_rdata;

    // Output register
    logic                 r_ov;
    t_status              r_ost;
    logic [INDEX_W-1:0]   r_oidx;
    logic [OFFSET_W-1:0]  r_ooff;

    logic                 w_req_acc;
    logic                 w_bad_bkt;
    logic [BSIZE_W-1:0]   w_bsz;
    logic [NB_W-1:0]      w_nblk;
    logic [WI_W-1:0]      w_last;
    logic [AW-1:0]        w_addr;
    int                   w_left;
    logic [WORD_BITS-1:0] w_vmask;
    logic [WORD_BITS-1:0] w_free;
    logic                 w_any;
    logic [WORD_LOG-1:0]  w_pos;
    logic                 w_used;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_out_free;
    logic [PRD_W-1:0]     w_prod;
    t_div_res             w_div;

    // Effective configuration: clamp sizes into their legal ranges
    always_comb begin
        if (r_cfg_bsz == '0) begin
            w_bsz = BSIZE_W'(1);
        end else if (r_cfg_bsz > MAX_BLOCK_BYTES) begin
            w_bsz = MAX_BLOCK_BYTES;
        end else begin
            w_bsz = r_cfg_bsz;
        end
        if (32'(r_cfg_nblk) > 32'(MAX_BLOCKS)) begin
            w_nblk = NB_W'(MAX_BLOCKS);
        end else begin
            w_nblk = NB_W'(r_cfg_nblk);
        end
    end

    assign w_bad_bkt = (32'(i_req.bucket_sel) >= 32'(r_cfg_nbkt))
                    || (32'(i_req.bucket_sel) >= 32'(MAX_BUCKETS));
    assign w_req_acc = i_req.valid && i_req.ready;
    assign w_last    = WI_W'((32'(w_nblk) - 32'd1) >> WORD_LOG);
    assign w_addr    = AW'(int'(r_bucket) * WPB + int'(r_word));

    // Valid blocks in the current word; mask off blocks past the count
    assign w_left  = int'(w_nblk) - int'(r_word) * WORD_BITS;
    assign w_vmask = (w_left >= WORD_BITS) ? '1 : ((32'd1 << w_left) - 32'd1);
    assign w_free  = ~r_rdata & w_vmask;
    assign w_any   = |w_free;
    assign w_used  = r_rdata[r_bitpos];

    // Lowest free bit of the word
    always_comb begin
        w_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_pos = WORD_LOG'(i);
            end
        end
    end

    // Byte offset of the allocated block
    assign w_prod = PRD_W'(r_blk) * PRD_W'(w_bsz);

    assign w_out_free = !r_ov || o_rsp.ready;

    // Memory write port: clearing pass, allocate set, free clear
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = r_rdata;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            ST_EVAL: begin
                if (r_op == OP_ALLOC) begin
                    w_we    = w_any;
                    w_wdata = r_rdata | (32'd1 << w_pos);
                end else begin
                    w_we    = w_used;
                    w_wdata = r_rdata & ~(32'd1 << r_bitpos);
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Bitmap storage with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == ST_READ) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bsz  <= RST_BLOCK_BYTES;
            r_cfg_nblk <= RST_BLOCKS;
            r_cfg_nbkt <= RST_BUCKETS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BLOCK_BYTES:    r_cfg_bsz  <= i_cfg.data;
                CFG_BLOCKS_IN_USE:  r_cfg_nblk <= i_cfg.data[NBLK_CFG_W-1:0];
                CFG_BUCKETS_IN_USE: r_cfg_nbkt <= i_cfg.data[NBKT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_req_acc && (i_req.opcode == OP_FREE) && !w_bad_bkt),
        .i_dividend (i_req.free_offset),
        .i_divisor  (w_bsz),
        .o_res      (w_div)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TOTAL - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_req_acc) begin
                        if (w_bad_bkt) begin
                            r_state <= ST_RESP;
                        end else if (i_req.opcode == OP_FREE) begin
                            r_state <= ST_DIV;
                        end else if (w_nblk == '0) begin
                            r_state <= ST_RESP;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        if (!w_div.exact || (w_div.quot >= OFFSET_W'(w_nblk))) begin
                            r_state <= ST_RESP;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (r_op == OP_FREE) begin
                        r_state <= ST_RESP;
                    end else if (w_any) begin
                        r_state <= ST_MUL;
                    end else if (r_word == w_last) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    r_op     <= i_req.opcode;
                    r_bucket <= i_req.bucket_sel;
                    r_word   <= '0;
                    r_blk    <= '0;
                    r_off    <= '0;
                    if (w_bad_bkt) begin
                        r_st <= STS_BAD_BUCKET;
                    end else begin
                        r_st <= STS_FULL;
                    end
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    r_st     <= STS_BAD_OFFSET;
                    r_word   <= WI_W'(w_div.quot >> WORD_LOG);
                    r_bitpos <= w_div.quot[WORD_LOG-1:0];
                    r_blk    <= BLK_W'(w_div.quot);
                end
            end
            ST_EVAL: begin
                if (r_op == OP_FREE) begin
                    r_st <= w_used ? STS_FREED : STS_NOT_USED;
                end else if (w_any) begin
                    r_st  <= STS_ALLOCATED;
                    r_blk <= BLK_W'(int'(r_word) * WORD_BITS + int'(w_pos));
                end else begin
                    r_word <= r_word + WI_W'(1);
                end
            end
            ST_MUL: begin
                r_off <= OFFSET_W'(w_prod);
            end
            default: begin
            end
        endcase
    end

    // Output register: load a finished response, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == ST_RESP) && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESP) && w_out_free) begin
            r_ost  <= r_st;
            r_oidx <= (r_st == STS_BAD_OFFSET) ? '0 : INDEX_W'(r_blk);
            r_ooff <= r_off;
        end
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_ost;
    assign o_rsp.block_index  = r_oidx;
    assign o_rsp.block_offset = r_ooff;

    // Checks on the sequencer and datapath
    `BBA_ASSERT_IMP(a_div_done_in_div, w_div.done, r_state == ST_DIV)
    `BBA_ASSERT_IMP(a_alloc_in_range, r_state == ST_MUL, 32'(r_blk) < 32'(w_nblk))
    `BBA_ASSERT_NXT(a_bad_bucket_resp, w_req_acc && w_bad_bkt,
                    (r_state == ST_RESP) && (r_st == STS_BAD_BUCKET))
    `BBA_ASSERT_IMP(a_no_write_idle, r_state == ST_IDLE, !w_we)

endmodule
